[sv/crc_pkg.sv]
// ----------------------------------------------------------------------------
// crc_pkg
// Shared widths, codes and types for the Catmull-Rom curve evaluator.
// ----------------------------------------------------------------------------
package crc_pkg;

   localparam int MAX_POINTS      = 256;
   localparam int PARAM_FRAC_BITS = 16;

   localparam int COORD_W = 32;
   localparam int PARAM_W = 24;
   localparam int IDX_W   = 8;
   localparam int CSR_W   = 9;

   localparam int PT_W       = $clog2(MAX_POINTS);
   localparam int BANKS      = 4;
   localparam int BANK_DEPTH = MAX_POINTS / BANKS;
   localparam int BANK_AW    = PT_W - 2;
   localparam int K_W        = PARAM_W - PARAM_FRAC_BITS;

   // doubled weights stay below 18 * 2^F in magnitude
   localparam int WGT_W  = PARAM_FRAC_BITS + 6;
   localparam int PROD_W = WGT_W + COORD_W;
   localparam int ACC_W  = PROD_W + 2;

   typedef logic signed [WGT_W-1:0]   crc_wgt_type;
   typedef logic signed [COORD_W-1:0] crc_coord_type;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_POS  = 2'd1,
      ACT_D1   = 2'd2,
      ACT_D2   = 2'd3
   } crc_action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SAT   = 2'd2
   } crc_status_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
      logic out_en;
      logic zero;
   } crc_ctl_type;

endpackage

[sv/catmull_rom_curve_evaluator.sv]
// ----------------------------------------------------------------------------
// catmull_rom_curve_evaluator
// Control point table in four banks and a six-stage Catmull-Rom blend pipe.
// ----------------------------------------------------------------------------
// channel  dir  handshake            beat contents
// req      in   req_valid/req_stall  action, point_index, coord_x/y/z, param_u
// rsp      out  rsp_valid/rsp_stall  out_x/y/z, status
// csr      in   csr_valid/csr_ready  points_in_use
//
// one beat per cycle in while req_stall is low; an evaluate beat shows on rsp
// after passing through these stages in order
// (bank read and square, cube, weights, multiply, pair add, round/saturate)
// a load beat writes one of four point banks (index mod 4) and gives no rsp beat
// synchronous reset clears valid bits and points_in_use, not the point banks
// a stalled rsp beat holds the output register; earlier stages keep filling
// ----------------------------------------------------------------------------
module catmull_rom_curve_evaluator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [crc_pkg::IDX_W-1:0]           req_point_index,
   input  logic signed [crc_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [crc_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [crc_pkg::COORD_W-1:0]  req_coord_z,
   input  logic [crc_pkg::PARAM_W-1:0]         req_param_u,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [crc_pkg::COORD_W-1:0]  rsp_out_x,
   output logic signed [crc_pkg::COORD_W-1:0]  rsp_out_y,
   output logic signed [crc_pkg::COORD_W-1:0]  rsp_out_z,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crc_pkg::CSR_W-1:0]           csr_wdata
);
   import crc_pkg::*;

   localparam int F     = PARAM_FRAC_BITS;
   localparam int SQ_W  = 2 * F;
   localparam int HALF  = 1 << (F - 1);
   localparam int RAM_W = 3 * COORD_W;
   localparam int CMP_A = (K_W + 2 > CSR_W + 1) ? K_W + 2 : CSR_W + 1;
   localparam int CMP_W = (CMP_A > PT_W + 1) ? CMP_A : PT_W + 1;

   localparam crc_wgt_type ONE_X1  = WGT_W'(1 << F);
   localparam crc_wgt_type ONE_X2  = WGT_W'(2 << F);
   localparam crc_wgt_type ONE_X4  = WGT_W'(4 << F);
   localparam crc_wgt_type ONE_X8  = WGT_W'(8 << F);
   localparam crc_wgt_type ONE_X10 = WGT_W'(10 << F);

   // configuration
   logic [CSR_W-1:0] piu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         piu_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         piu_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   // pipeline control
   logic [6:1] vld_ff;
   logic [6:1] vld_in;
   logic [6:1] rdy;
   logic       accept;
   logic       is_load;

   assign is_load = crc_action_type'(req_action) == ACT_LOAD;
   assign accept  = req_valid && rdy[1];

   always_comb begin
      rdy[6] = !vld_ff[6] || !rsp_stall;
      for (int i = 5; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[1] = rdy[1] ? (req_valid && !is_load) : vld_ff[1];
      for (int i = 2; i <= 6; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !rdy[1];
   assign rsp_valid = vld_ff[6];

   // front end: segment split, square, range check, bank addressing
   logic [F-1:0]       t_in;
   logic [K_W-1:0]     seg_k;
   logic [SQ_W-1:0]    sq;
   logic [CMP_W-1:0]   limit;
   logic               oor_in;
   logic [PT_W-1:0]    wr_idx;
   logic               in_depth;
   logic [BANKS-1:0]   wr_en;
   logic [1:0]         rd_off [BANKS];
   logic [PT_W-1:0]    rd_idx [BANKS];
   logic [BANK_AW-1:0] rd_addr [BANKS];
   logic [RAM_W-1:0]   bank_q [BANKS];

   assign t_in  = req_param_u[F-1:0];
   assign seg_k = req_param_u[PARAM_W-1:F];
   assign sq    = SQ_W'(t_in) * SQ_W'(t_in) + SQ_W'(HALF);

   always_comb begin
      limit = (CMP_W'(piu_ff) > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS)
                                                   : CMP_W'(piu_ff);
      oor_in = (CMP_W'(seg_k) + CMP_W'(3)) >= limit;
   end

   assign wr_idx   = PT_W'(req_point_index);
   assign in_depth = 32'(req_point_index) < MAX_POINTS;

   // bank b holds every point whose index is b mod 4
   always_comb begin
      for (int b = 0; b < BANKS; b++) begin
         wr_en[b]   = accept && is_load && in_depth && (req_point_index[1:0] == 2'(b));
         rd_off[b]  = 2'(b) - req_param_u[F+1:F];
         rd_idx[b]  = PT_W'(seg_k) + PT_W'(rd_off[b]);
         rd_addr[b] = rd_idx[b][PT_W-1:2];
      end
   end

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      crc_ram #(
         .WIDTH (RAM_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_idx[PT_W-1:2]),
         .wr_data ({req_coord_x, req_coord_y, req_coord_z}),
         .rd_en   (rdy[1]),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_q[b])
      );
   end

   // stage 1
   logic [F-1:0]   s1_t_ff;
   logic [F-1:0]   s1_t2_ff;
   crc_action_type s1_act_ff;
   logic           s1_oor_ff;
   logic [1:0]     s1_klo_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_t_ff   <= t_in;
         s1_t2_ff  <= sq[SQ_W-1:F];
         s1_act_ff <= crc_action_type'(req_action);
         s1_oor_ff <= oor_in;
         s1_klo_ff <= req_param_u[F+1:F];
      end
   end

   // stage 2: cube and point reorder
   logic [SQ_W-1:0] cube;
   logic [1:0]      sel [4];
   crc_coord_type   s2_px_in [4];
   crc_coord_type   s2_py_in [4];
   crc_coord_type   s2_pz_in [4];
   crc_coord_type   s2_px_ff [4];
   crc_coord_type   s2_py_ff [4];
   crc_coord_type   s2_pz_ff [4];
   logic [F-1:0]    s2_t_ff;
   logic [F-1:0]    s2_t2_ff;
   logic [F-1:0]    s2_t3_ff;
   crc_action_type  s2_act_ff;
   logic            s2_oor_ff;

   assign cube = SQ_W'(s1_t2_ff) * SQ_W'(s1_t_ff) + SQ_W'(HALF);

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         sel[j]      = s1_klo_ff + 2'(j);
         s2_px_in[j] = bank_q[sel[j]][3*COORD_W-1:2*COORD_W];
         s2_py_in[j] = bank_q[sel[j]][2*COORD_W-1:COORD_W];
         s2_pz_in[j] = bank_q[sel[j]][COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_t_ff   <= s1_t_ff;
         s2_t2_ff  <= s1_t2_ff;
         s2_t3_ff  <= cube[SQ_W-1:F];
         s2_act_ff <= s1_act_ff;
         s2_oor_ff <= s1_oor_ff;
         s2_px_ff  <= s2_px_in;
         s2_py_ff  <= s2_py_in;
         s2_pz_ff  <= s2_pz_in;
      end
   end

   // stage 3: doubled basis weights, shift-add only
   crc_wgt_type   ts;
   crc_wgt_type   t2s;
   crc_wgt_type   t3s;
   crc_wgt_type   s3_wgt_in [4];
   crc_wgt_type   s3_wgt_ff [4];
   crc_coord_type s3_px_ff [4];
   crc_coord_type s3_py_ff [4];
   crc_coord_type s3_pz_ff [4];
   logic          s3_oor_ff;

   always_comb begin
      ts  = WGT_W'(s2_t_ff);
      t2s = WGT_W'(s2_t2_ff);
      t3s = WGT_W'(s2_t3_ff);
      case (s2_act_ff)
         ACT_POS: begin
            s3_wgt_in[0] = (t2s <<< 1) - t3s - ts;
            s3_wgt_in[1] = (t3s <<< 1) + t3s - ((t2s <<< 2) + t2s) + ONE_X2;
            s3_wgt_in[2] = (t2s <<< 2) + ts - ((t3s <<< 1) + t3s);
            s3_wgt_in[3] = t3s - t2s;
         end
         ACT_D1: begin
            s3_wgt_in[0] = (ts <<< 2) - ((t2s <<< 1) + t2s) - ONE_X1;
            s3_wgt_in[1] = (t2s <<< 3) + t2s - ((ts <<< 3) + (ts <<< 1));
            s3_wgt_in[2] = (ts <<< 3) + ONE_X1 - ((t2s <<< 3) + t2s);
            s3_wgt_in[3] = (t2s <<< 1) + t2s - (ts <<< 1);
         end
         ACT_D2: begin
            s3_wgt_in[0] = ONE_X4 - ((ts <<< 2) + (ts <<< 1));
            s3_wgt_in[1] = (ts <<< 4) + (ts <<< 1) - ONE_X10;
            s3_wgt_in[2] = ONE_X8 - ((ts <<< 4) + (ts <<< 1));
            s3_wgt_in[3] = (ts <<< 2) + (ts <<< 1) - ONE_X2;
         end
         default: begin
            for (int j = 0; j < 4; j++) begin
               s3_wgt_in[j] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_wgt_ff <= s3_wgt_in;
         s3_px_ff  <= s2_px_ff;
         s3_py_ff  <= s2_py_ff;
         s3_pz_ff  <= s2_pz_ff;
         s3_oor_ff <= s2_oor_ff;
      end
   end

   // stages 4 to 6: out-of-range flag rides alongside the axis pipes
   logic        s4_oor_ff;
   logic        s5_oor_ff;
   logic        s6_oor_ff;
   crc_ctl_type ctl;
   logic        sat_x;
   logic        sat_y;
   logic        sat_z;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_oor_ff <= s3_oor_ff;
      end
      if (rdy[5]) begin
         s5_oor_ff <= s4_oor_ff;
      end
      if (rdy[6]) begin
         s6_oor_ff <= s5_oor_ff;
      end
   end

   assign ctl = '{prod_en: rdy[4], sum_en: rdy[5], out_en: rdy[6], zero: s5_oor_ff};

   crc_axis u_axis_x (
      .clock  (clock),
      .ctl    (ctl),
      .weight (s3_wgt_ff),
      .point  (s3_px_ff),
      .value  (rsp_out_x),
      .sat    (sat_x)
   );

   crc_axis u_axis_y (
      .clock  (clock),
      .ctl    (ctl),
      .weight (s3_wgt_ff),
      .point  (s3_py_ff),
      .value  (rsp_out_y),
      .sat    (sat_y)
   );

   crc_axis u_axis_z (
      .clock  (clock),
      .ctl    (ctl),
      .weight (s3_wgt_ff),
      .point  (s3_pz_ff),
      .value  (rsp_out_z),
      .sat    (sat_z)
   );

   assign rsp_status = s6_oor_ff               ? ST_RANGE :
                       (sat_x | sat_y | sat_z) ? ST_SAT   : ST_OK;

endmodule

[sv/crc_ram.sv]
// ----------------------------------------------------------------------------
// crc_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/crc_axis.sv]
// ----------------------------------------------------------------------------
// crc_axis
// One coordinate of the blend: four products, pair sums, then round,
// saturate (or force zero when out of range) and output register.
// ----------------------------------------------------------------------------
module crc_axis (
   input  logic                  clock,
   input  crc_pkg::crc_ctl_type  ctl,
   input  crc_pkg::crc_wgt_type  weight [4],
   input  crc_pkg::crc_coord_type point [4],
   output crc_pkg::crc_coord_type value,
   output logic                  sat
);
   import crc_pkg::*;

   localparam int SH_W = ACC_W - PARAM_FRAC_BITS - 1;
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< PARAM_FRAC_BITS;
   localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_in [4];
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W:0]   pair_in [2];
   logic signed [PROD_W:0]   pair_ff [2];
   logic signed [ACC_W-1:0]  total;
   logic [SH_W-1:0]          shifted;
   logic                     ovf;
   crc_coord_type            value_in;
   crc_coord_type            value_ff;
   logic                     sat_in;
   logic                     sat_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         prod_in[j] = PROD_W'(weight[j]) * PROD_W'(point[j]);
      end
      pair_in[0] = (PROD_W+1)'(prod_ff[0]) + (PROD_W+1)'(prod_ff[1]);
      pair_in[1] = (PROD_W+1)'(prod_ff[2]) + (PROD_W+1)'(prod_ff[3]);
   end

   // round half up, then floor shift by F+1 (weights are doubled)
   always_comb begin
      total   = ACC_W'(pair_ff[0]) + ACC_W'(pair_ff[1]) + RND;
      shifted = total[ACC_W-1:PARAM_FRAC_BITS+1];
      ovf     = shifted[SH_W-1:COORD_W-1] != {(SH_W-COORD_W+1){shifted[SH_W-1]}};
      if (ctl.zero) begin
         value_in = '0;
         sat_in   = 1'b0;
      end else if (ovf) begin
         value_in = shifted[SH_W-1] ? NEG_MIN : POS_MAX;
         sat_in   = 1'b1;
      end else begin
         value_in = shifted[COORD_W-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.sum_en) begin
         pair_ff <= pair_in;
      end
      if (ctl.out_en) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign value = value_ff;
   assign sat   = sat_ff;

endmodule

[sv/crc_checker.sv]
// ----------------------------------------------------------------------------
// crc_checker
// Port-level checks for the Catmull-Rom curve evaluator, bound to the top.
// ----------------------------------------------------------------------------
module crc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [crc_pkg::COORD_W-1:0] rsp_out_x,
   input logic signed [crc_pkg::COORD_W-1:0] rsp_out_y,
   input logic signed [crc_pkg::COORD_W-1:0] rsp_out_z,
   input logic [1:0]                         rsp_status
);
   import crc_pkg::*;

   localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   a_hold_under_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_range_gives_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_RANGE |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("out of range beat with nonzero coordinates");

   a_sat_at_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAT |->
         rsp_out_x == POS_MAX || rsp_out_x == NEG_MIN ||
         rsp_out_y == POS_MAX || rsp_out_y == NEG_MIN ||
         rsp_out_z == POS_MAX || rsp_out_z == NEG_MIN)
      else $error("saturated beat with no coordinate at a bound");

endmodule

bind catmull_rom_curve_evaluator crc_checker u_checker (.*);
